[rtl/core/bcm_pkg.sv]
// bcm_pkg: shared codes, opcodes and helpers of the byte-coded machine.
// No dependencies; compiled first.
package bcm_pkg;

    // Commands carried by one input item
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HALT   = 3'd1;
    localparam logic [2:0] ST_BADOP  = 3'd2;
    localparam logic [2:0] ST_FAULT  = 3'd3;
    localparam logic [2:0] ST_BADINT = 3'd4;

    // Opcodes
    localparam logic [7:0] OP_NOP    = 8'd19;
    localparam logic [7:0] OP_INT    = 8'd20;
    localparam logic [7:0] OP_LDI    = 8'd1;
    localparam logic [7:0] OP_STI_A  = 8'd2;
    localparam logic [7:0] OP_STI_R  = 8'd3;
    localparam logic [7:0] OP_MOV    = 8'd7;
    localparam logic [7:0] OP_STR_A  = 8'd8;
    localparam logic [7:0] OP_STR_R  = 8'd9;
    localparam logic [7:0] OP_ADD    = 8'd23;

    // Interrupt codes
    localparam logic [15:0] INT_HALT    = 16'd10;
    localparam logic [15:0] INT_OUT_INT = 16'd11;
    localparam logic [15:0] INT_OUT_FLT = 16'd12;
    localparam logic [15:0] INT_IN_INT  = 16'd13;
    localparam logic [15:0] INT_IN_FLT  = 16'd14;

    // Register file layout
    localparam int unsigned NUM_INT_REGS = 7;
    localparam logic [2:0]  REG_R0       = 3'd0;
    localparam logic [2:0]  REG_SP       = 3'd5;
    localparam logic [2:0]  REG_PC       = 3'd6;
    localparam int unsigned RF_DEPTH     = 6;   // registers below the pc live in memory

    typedef logic [15:0] word_t;

    // Instruction length in bytes; zero marks an unknown opcode
    function automatic logic [2:0] insn_len(input logic [7:0] op);
        logic [2:0] len;
        begin
            case (op)
                OP_NOP:   len = 3'd1;
                OP_INT:   len = 3'd3;
                OP_LDI:   len = 3'd4;
                OP_STI_A: len = 3'd5;
                OP_STI_R: len = 3'd4;
                OP_MOV:   len = 3'd3;
                OP_STR_A: len = 3'd4;
                OP_STR_R: len = 3'd3;
                OP_ADD:   len = 3'd3;
                default:  len = 3'd0;
            endcase
            return len;
        end
    endfunction

endpackage

[rtl/core/bcm_if.sv]
// bcm_if: valid/ready channels for command items and result items.
// Depends on nothing; compiled after bcm_pkg.
interface bcm_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  byte_value;
    logic [15:0] program_length;
    logic [31:0] input_value;

    modport source (output valid, command, address, byte_value, program_length, input_value,
                    input ready);
    modport sink   (input valid, command, address, byte_value, program_length, input_value,
                    output ready);
endinterface

interface bcm_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        out_valid;
    logic        out_is_float;
    logic [31:0] out_value;
    logic [15:0] pc_after;

    modport source (output valid, status, out_valid, out_is_float, out_value, pc_after,
                    input ready);
    modport sink   (input valid, status, out_valid, out_is_float, out_value, pc_after,
                    output ready);
endinterface

[rtl/core/bcm_code_mem.sv]
// bcm_code_mem: single-port byte memory, registered read data.
// No package dependency; contents undefined until written.
module bcm_code_mem #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = 13
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/bcm_reg_mem.sv]
// bcm_reg_mem: integer registers below the pc, one write and one read port.
// Uses bcm_pkg; per-entry valid bits give the zero reset value.
module bcm_reg_mem (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           we,
    input  logic [2:0]     waddr,
    input  bcm_pkg::word_t wdata,
    input  logic [2:0]     raddr,
    output bcm_pkg::word_t rdata
);

    bcm_pkg::word_t                 mem [0:bcm_pkg::RF_DEPTH-1];
    logic [bcm_pkg::RF_DEPTH-1:0]   vld_reg;
    bcm_pkg::word_t                 rdata_reg;

    logic wr_ok;
    logic rd_ok;

    assign wr_ok = we && (waddr < 3'(bcm_pkg::RF_DEPTH));
    assign rd_ok = raddr < 3'(bcm_pkg::RF_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_ok)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[waddr] <= wdata;
        end
        // entries never written read as zero
        if (rd_ok && vld_reg[raddr])
        begin
            rdata_reg <= mem[raddr];
        end
        else
        begin
            rdata_reg <= '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/bytecode_machine_step.sv]
// bytecode_machine_step: top level of the byte-coded machine, with the step sequencer.
// Uses bcm_pkg, bcm_if, bcm_code_mem and bcm_reg_mem.
//
// Usage
//   cmd: one command item per handshake (write program byte, start, step).
//   res: exactly one result item for every command item, in order.
//   cmd.ready is high only while the sequencer is idle and the result register
//   is empty, so one item is in flight at a time.
// Sequence
//   Write, start, unknown command, and a step refused up front (halted, or pc
//   beyond memory): result valid in the cycle after the item is taken.
//   Step: fetch of the five instruction bytes, decode, operand read, execute;
//   the result is loaded in execute. A store writes its high byte in a further state.
//   The next step item waits until this one is through; the five instruction
//   bytes are pulled one per cycle from the one-port byte memory.
// Reset
//   Machine halted, registers and float register zero; code memory is not
//   cleared, so no clearing pass is needed. Unwritten bytes read as garbage.
// Stall
//   While res.ready is low the result holds and no new item is taken.
module bytecode_machine_step #(
    parameter int unsigned MEM_BYTES = 8192
) (
    input  logic           clk,
    input  logic           rst_n,
    bcm_cmd_if.sink        cmd,
    bcm_res_if.source      res
);

    localparam int unsigned AW       = $clog2(MEM_BYTES);
    localparam logic [16:0] MEM_SIZE = 17'(MEM_BYTES);

    // one-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_DECODE = 6'b000100,
        S_READB  = 6'b001000,
        S_EXEC   = 6'b010000,
        S_STORE2 = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // architectural state held in flops
    bcm_pkg::word_t pc_reg, pc_next;
    logic           halted_reg, halted_next;
    logic [31:0]    flt_reg, flt_next;

    // step working registers
    logic [31:0]    ival_reg, ival_next;
    logic [2:0]     iss_reg, iss_next;
    logic [7:0]     insn_reg [0:4];
    logic [7:0]     insn_next [0:4];
    bcm_pkg::word_t va_reg, va_next;
    logic [AW-1:0]  st_addr_reg, st_addr_next;
    logic [7:0]     st_hi_reg, st_hi_next;

    // result register
    logic           res_valid_reg, res_valid_next;
    logic [2:0]     res_status_reg, res_status_next;
    logic           res_ov_reg, res_ov_next;
    logic           res_fl_reg, res_fl_next;
    logic [31:0]    res_val_reg, res_val_next;
    bcm_pkg::word_t res_pc_reg, res_pc_next;

    // memory ports
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [7:0]     mem_wdata;
    logic [7:0]     mem_rdata;
    logic           rf_we;
    logic [2:0]     rf_waddr;
    bcm_pkg::word_t rf_wdata;
    logic [2:0]     rf_raddr;
    bcm_pkg::word_t rf_rdata;

    // decode helpers
    logic           accept;
    logic [7:0]     op;
    bcm_pkg::word_t imm;
    logic [2:0]     ilen;
    bcm_pkg::word_t pc_adv;
    bcm_pkg::word_t fetch_addr;
    logic [2:0]     ia;
    logic [2:0]     ib;
    bcm_pkg::word_t vb;
    logic [16:0]    end_addr;

    // result and execute scratch
    logic           load_res;
    logic [2:0]     r_status;
    logic           r_ov;
    logic           r_fl;
    logic [31:0]    r_val;
    logic           fault;
    logic           wr_en;
    logic [2:0]     wr_idx;
    bcm_pkg::word_t wr_val;
    logic           st_en;
    bcm_pkg::word_t st_addr;
    bcm_pkg::word_t st_val;

    bcm_code_mem #(
        .DEPTH (MEM_BYTES),
        .AW    (AW)
    ) u_code_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bcm_reg_mem u_reg_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    assign cmd.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign accept    = cmd.valid && cmd.ready;

    assign res.valid        = res_valid_reg;
    assign res.status       = res_status_reg;
    assign res.out_valid    = res_ov_reg;
    assign res.out_is_float = res_fl_reg;
    assign res.out_value    = res_val_reg;
    assign res.pc_after     = res_pc_reg;

    assign op         = insn_reg[0];
    assign imm        = {insn_reg[2], insn_reg[1]};
    assign ilen       = bcm_pkg::insn_len(op);
    assign pc_adv     = pc_reg + 16'(ilen);
    assign fetch_addr = pc_reg + 16'(iss_reg);
    assign end_addr   = {1'b0, pc_reg} + 17'(ilen);

    // first operand register: r0 for interrupts, the address register for
    // opcode 3, otherwise the first operand byte
    always_comb
    begin
        case (op)
            bcm_pkg::OP_INT:   ia = bcm_pkg::REG_R0;
            bcm_pkg::OP_STI_R: ia = insn_reg[3][2:0];
            default:           ia = insn_reg[1][2:0];
        endcase
    end

    assign ib = insn_reg[2][2:0];
    assign vb = (ib == bcm_pkg::REG_PC) ? pc_reg : rf_rdata;

    // execute: work out register write, store and result of the instruction
    always_comb
    begin
        fault    = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = bcm_pkg::REG_R0;
        wr_val   = '0;
        st_en    = 1'b0;
        st_addr  = '0;
        st_val   = '0;
        r_status = bcm_pkg::ST_OK;
        r_ov     = 1'b0;
        r_fl     = 1'b0;
        r_val    = '0;
        case (op)
            bcm_pkg::OP_INT:
            begin
                if (imm == bcm_pkg::INT_HALT)
                begin
                    r_status = bcm_pkg::ST_HALT;
                end
                else if (imm == bcm_pkg::INT_OUT_INT)
                begin
                    r_ov  = 1'b1;
                    r_val = {{16{va_reg[15]}}, va_reg};
                end
                else if (imm == bcm_pkg::INT_OUT_FLT)
                begin
                    r_ov  = 1'b1;
                    r_fl  = 1'b1;
                    r_val = flt_reg;
                end
                else if (imm == bcm_pkg::INT_IN_INT)
                begin
                    wr_en  = 1'b1;
                    wr_idx = bcm_pkg::REG_R0;
                    wr_val = ival_reg[15:0];
                end
                else if (imm != bcm_pkg::INT_IN_FLT)
                begin
                    r_status = bcm_pkg::ST_BADINT;
                end
            end
            bcm_pkg::OP_LDI:
            begin
                fault  = insn_reg[3] >= 8'(bcm_pkg::NUM_INT_REGS);
                wr_en  = 1'b1;
                wr_idx = insn_reg[3][2:0];
                wr_val = imm;
            end
            bcm_pkg::OP_STI_A:
            begin
                st_addr = {insn_reg[4], insn_reg[3]};
                fault   = ({1'b0, st_addr} + 17'd1) >= MEM_SIZE;
                st_en   = 1'b1;
                st_val  = imm;
            end
            bcm_pkg::OP_STI_R:
            begin
                st_addr = va_reg;
                fault   = (insn_reg[3] >= 8'(bcm_pkg::NUM_INT_REGS))
                       || (({1'b0, st_addr} + 17'd1) >= MEM_SIZE);
                st_en   = 1'b1;
                st_val  = imm;
            end
            bcm_pkg::OP_MOV:
            begin
                fault  = (insn_reg[1] >= 8'(bcm_pkg::NUM_INT_REGS))
                      || (insn_reg[2] >= 8'(bcm_pkg::NUM_INT_REGS));
                wr_en  = 1'b1;
                wr_idx = ib;
                wr_val = va_reg;
            end
            bcm_pkg::OP_STR_A:
            begin
                st_addr = {insn_reg[3], insn_reg[2]};
                fault   = (insn_reg[1] >= 8'(bcm_pkg::NUM_INT_REGS))
                       || (({1'b0, st_addr} + 17'd1) >= MEM_SIZE);
                st_en   = 1'b1;
                st_val  = va_reg;
            end
            bcm_pkg::OP_STR_R:
            begin
                st_addr = vb;
                fault   = (insn_reg[1] >= 8'(bcm_pkg::NUM_INT_REGS))
                       || (insn_reg[2] >= 8'(bcm_pkg::NUM_INT_REGS))
                       || (({1'b0, st_addr} + 17'd1) >= MEM_SIZE);
                st_en   = 1'b1;
                st_val  = va_reg;
            end
            bcm_pkg::OP_ADD:
            begin
                fault  = (insn_reg[1] >= 8'(bcm_pkg::NUM_INT_REGS))
                      || (insn_reg[2] >= 8'(bcm_pkg::NUM_INT_REGS));
                wr_en  = 1'b1;
                wr_idx = ib;
                wr_val = vb + va_reg;
            end
            default:
            begin
                // nop: only the pc advance
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        halted_next  = halted_reg;
        flt_next     = flt_reg;
        ival_next    = ival_reg;
        iss_next     = iss_reg;
        insn_next    = insn_reg;
        va_next      = va_reg;
        st_addr_next = st_addr_reg;
        st_hi_next   = st_hi_reg;

        res_valid_next = res_valid_reg && !res.ready;
        load_res       = 1'b0;
        res_status_next = res_status_reg;
        res_ov_next     = res_ov_reg;
        res_fl_next     = res_fl_reg;
        res_val_next    = res_val_reg;
        res_pc_next     = res_pc_reg;

        mem_we    = 1'b0;
        mem_addr  = fetch_addr[AW-1:0];
        mem_wdata = '0;
        rf_we     = 1'b0;
        rf_waddr  = bcm_pkg::REG_R0;
        rf_wdata  = '0;
        rf_raddr  = bcm_pkg::REG_R0;

        res_status_next = load_res ? bcm_pkg::ST_OK : res_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ival_next = cmd.input_value;
                    load_res  = 1'b1;
                    res_status_next = bcm_pkg::ST_OK;
                    res_ov_next     = 1'b0;
                    res_fl_next     = 1'b0;
                    res_val_next    = '0;
                    case (cmd.command)
                        bcm_pkg::CMD_WRITE:
                        begin
                            mem_addr  = cmd.address[AW-1:0];
                            mem_wdata = cmd.byte_value;
                            if ({1'b0, cmd.address} < MEM_SIZE)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                res_status_next = bcm_pkg::ST_FAULT;
                            end
                        end
                        bcm_pkg::CMD_START:
                        begin
                            pc_next     = cmd.address;
                            halted_next = 1'b0;
                            rf_we       = 1'b1;
                            rf_waddr    = bcm_pkg::REG_SP;
                            rf_wdata    = cmd.program_length + 16'd1;
                        end
                        bcm_pkg::CMD_STEP:
                        begin
                            if (halted_reg)
                            begin
                                res_status_next = bcm_pkg::ST_HALT;
                            end
                            else if ({1'b0, pc_reg} >= MEM_SIZE)
                            begin
                                res_status_next = bcm_pkg::ST_FAULT;
                            end
                            else
                            begin
                                load_res   = 1'b0;
                                iss_next   = '0;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            // unknown command: no effect
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // read byte iss, capture the byte read in the previous cycle
                if (iss_reg != 3'd0)
                begin
                    insn_next[iss_reg - 3'd1] = mem_rdata;
                end
                iss_next = iss_reg + 3'd1;
                if (iss_reg == 3'd4)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                insn_next[4] = mem_rdata;
                rf_raddr     = ia;
                state_next   = S_READB;
            end
            S_READB:
            begin
                va_next    = (ia == bcm_pkg::REG_PC) ? pc_reg : rf_rdata;
                rf_raddr   = ib;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                load_res        = 1'b1;
                state_next      = S_IDLE;
                res_status_next = r_status;
                res_ov_next     = 1'b0;
                res_fl_next     = 1'b0;
                res_val_next    = '0;
                if (ilen == 3'd0)
                begin
                    halted_next     = 1'b1;
                    res_status_next = bcm_pkg::ST_BADOP;
                end
                else if (end_addr > MEM_SIZE || fault)
                begin
                    res_status_next = bcm_pkg::ST_FAULT;
                end
                else
                begin
                    res_ov_next  = r_ov;
                    res_fl_next  = r_fl;
                    res_val_next = r_val;
                    if (op == bcm_pkg::OP_INT && imm == bcm_pkg::INT_HALT)
                    begin
                        halted_next = 1'b1;
                    end
                    if (op == bcm_pkg::OP_INT && imm == bcm_pkg::INT_IN_FLT)
                    begin
                        flt_next = ival_reg;
                    end
                    // register write first, then the advance (also onto a new pc)
                    pc_next = pc_adv;
                    if (wr_en)
                    begin
                        if (wr_idx == bcm_pkg::REG_PC)
                        begin
                            pc_next = wr_val + 16'(ilen);
                        end
                        else
                        begin
                            rf_we    = 1'b1;
                            rf_waddr = wr_idx;
                            rf_wdata = wr_val;
                        end
                    end
                    if (st_en)
                    begin
                        mem_we       = 1'b1;
                        mem_addr     = st_addr[AW-1:0];
                        mem_wdata    = st_val[7:0];
                        st_addr_next = st_addr[AW-1:0];
                        st_hi_next   = st_val[15:8];
                        state_next   = S_STORE2;
                    end
                end
            end
            S_STORE2:
            begin
                mem_we     = 1'b1;
                mem_addr   = st_addr_reg + AW'(1);
                mem_wdata  = st_hi_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_res)
        begin
            res_valid_next = 1'b1;
            res_pc_next    = pc_next;
        end
        else
        begin
            res_status_next = (state_reg == S_IDLE) ? res_status_reg : res_status_next;
            res_ov_next     = (state_reg == S_IDLE) ? res_ov_reg : res_ov_next;
            res_fl_next     = (state_reg == S_IDLE) ? res_fl_reg : res_fl_next;
            res_val_next    = (state_reg == S_IDLE) ? res_val_reg : res_val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            halted_reg    <= 1'b1;
            flt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            halted_reg    <= halted_next;
            flt_reg       <= flt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ival_reg       <= ival_next;
        iss_reg        <= iss_next;
        insn_reg       <= insn_next;
        va_reg         <= va_next;
        st_addr_reg    <= st_addr_next;
        st_hi_reg      <= st_hi_next;
        res_status_reg <= res_status_next;
        res_ov_reg     <= res_ov_next;
        res_fl_reg     <= res_fl_next;
        res_val_reg    <= res_val_next;
        res_pc_reg     <= res_pc_next;
    end

endmodule
